@@ sv/tkdva_pkg.sv @@
package tkdva_pkg;

  localparam int unsigned KeyW   = 6;
  localparam int unsigned MeasW  = 16;
  localparam int unsigned CntW   = 8;
  localparam int unsigned EvW    = 2;
  localparam int unsigned VoiceW = 3;

  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [MeasW-1:0] ThrReset = 16'd1000;
  localparam logic [CntW-1:0]  DebReset = 8'd4;

  localparam logic RegThr = 1'b0;
  localparam logic RegDeb = 1'b1;

  localparam logic [EvW-1:0] EvNone  = 2'd0;
  localparam logic [EvW-1:0] EvStart = 2'd1;
  localparam logic [EvW-1:0] EvStop  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KeyW-1:0]  key_index;
    logic [MeasW-1:0] measured_count;
  } req_t;

  typedef struct packed {
    logic [EvW-1:0]    event_res;
    logic [VoiceW-1:0] voice_index;
    logic [KeyW-1:0]   event_key;
  } evt_t;

  typedef struct packed {
    kind_e           kind;
    logic [KeyW-1:0] key;
  } qent_t;

endpackage

@@ sv/touch_key_debounce_voice_allocator_core.sv @@
// throughput: one request per cycle while the queue has room; the counter ram
// read and write-back overlap with a one-entry bypass, and a four-entry queue
// decouples classify from allocate
// reset: all keys released, counters zero, no voice owned, next voice zero,
// threshold 1000, debounce 4; no clearing pass
module touch_key_debounce_voice_allocator_core import tkdva_pkg::*; #(
  parameter int unsigned KEY_COUNT   = 64,
  parameter int unsigned VOICE_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             evt_valid_o,
  input  logic             evt_ready_i,
  output evt_t             evt_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [MeasW-1:0] thr_q;
  logic [CntW-1:0]  deb_q;
  logic             cfg_we;
  logic             push;
  qent_t            push_data;
  logic             pop;
  logic             q_valid;
  qent_t            q_data;
  logic [QCntW-1:0] q_level;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      deb_q <= DebReset;
    end else if (cfg_we) begin
      unique case (paddr[2])
        RegThr:  thr_q <= pwdata[MeasW-1:0];
        RegDeb:  deb_q <= pwdata[CntW-1:0];
        default: thr_q <= thr_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegThr:  prdata = DataW'(thr_q);
      RegDeb:  prdata = DataW'(deb_q);
      default: prdata = '0;
    endcase
  end

  tkdva_front #(
    .KEY_COUNT(KEY_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .thr_i       (thr_q),
    .deb_i       (deb_q),
    .q_level_i   (q_level),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tkdva_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .level_o     (q_level)
  );

  tkdva_back #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .evt_valid_o (evt_valid_o),
    .evt_ready_i (evt_ready_i),
    .evt_o       (evt_o)
  );

endmodule

@@ sv/tkdva_ram.sv @@
module tkdva_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tkdva_front.sv @@
module tkdva_front import tkdva_pkg::*; #(
  parameter int unsigned KEY_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_i,
  input  logic [MeasW-1:0]  thr_i,
  input  logic [CntW-1:0]   deb_i,
  input  logic [QCntW-1:0]  q_level_i,
  output logic              push_o,
  output qent_t             push_data_o
);

  localparam int unsigned KeyIdxW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic                  accept;
  logic                  s1_vld_q;
  logic [KeyW-1:0]       s1_key_q;
  logic [MeasW-1:0]      s1_meas_q;
  logic [KeyIdxW-1:0]    idx;
  logic                  in_rng;
  logic [KEY_COUNT-1:0]  cnt_vld_q;
  logic                  wr_vld_q;
  logic [KeyIdxW-1:0]    wr_idx_q;
  logic [CntW:0]         wr_ent_q;
  logic [CntW:0]         rdata;
  logic [CntW:0]         ent_cur;
  logic [CntW-1:0]       cnt_cur;
  logic [CntW:0]         inc;
  logic                  touched;
  logic                  pressed;
  logic                  pressed_nxt;
  logic                  flip;
  logic [CntW-1:0]       cnt_nxt;
  logic [CntW:0]         wdata;
  kind_e                 kind;
  logic                  we;

  assign req_ready_o = ({1'b0, q_level_i} + (QCntW+1)'(s1_vld_q)) < (QCntW+1)'(QDepth);
  assign accept      = req_valid_i & req_ready_o;

  // pressed flag above the debounce count
  tkdva_ram #(
    .Width(CntW + 1),
    .Depth(KEY_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (KeyIdxW'(req_i.key_index)),
    .rdata_o (rdata)
  );

  assign idx     = KeyIdxW'(s1_key_q);
  assign in_rng  = 32'(s1_key_q) < 32'(KEY_COUNT);
  assign touched = s1_meas_q > thr_i;
  assign we      = s1_vld_q & in_rng;

  always_comb begin
    if (!cnt_vld_q[idx]) begin
      ent_cur = '0;
    end else if (wr_vld_q && (wr_idx_q == idx)) begin
      ent_cur = wr_ent_q;
    end else begin
      ent_cur = rdata;
    end
  end

  assign pressed = ent_cur[CntW];
  assign cnt_cur = ent_cur[CntW-1:0];
  assign inc     = {1'b0, cnt_cur} + (CntW+1)'(1);

  always_comb begin
    flip    = 1'b0;
    cnt_nxt = '0;
    kind    = KIND_NONE;
    if (touched != pressed) begin
      if (inc >= {1'b0, deb_i}) begin
        flip = 1'b1;
        kind = touched ? KIND_PRESS : KIND_RELEASE;
      end else begin
        cnt_nxt = inc[CntW-1:0];
      end
    end
    if (!in_rng) begin
      kind = KIND_NONE;
    end
  end

  assign pressed_nxt = flip ? touched : pressed;
  assign wdata       = {pressed_nxt, cnt_nxt};

  assign push_o           = s1_vld_q;
  assign push_data_o.kind = kind;
  assign push_data_o.key  = s1_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
      cnt_vld_q <= '0;
    end else begin
      s1_vld_q <= accept;
      wr_vld_q <= we;
      if (we) begin
        cnt_vld_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_key_q  <= req_i.key_index;
      s1_meas_q <= req_i.measured_count;
    end
    if (we) begin
      wr_idx_q <= idx;
      wr_ent_q <= wdata;
    end
  end

endmodule

@@ sv/tkdva_fifo.sv @@
module tkdva_fifo import tkdva_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qent_t            push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output qent_t            data_o,
  output logic [QCntW-1:0] level_o
);

  qent_t              mem_q [QDepth];
  logic [QPtrW-1:0]   wptr_q;
  logic [QPtrW-1:0]   rptr_q;
  logic [QCntW-1:0]   cnt_q;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign level_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/tkdva_back.sv @@
module tkdva_back import tkdva_pkg::*; #(
  parameter int unsigned VOICE_COUNT = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  qent_t q_data_i,
  output logic  pop_o,
  output logic  evt_valid_o,
  input  logic  evt_ready_i,
  output evt_t  evt_o
);

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  logic [VOICE_COUNT-1:0] own_vld_q;
  logic [KeyW-1:0]        own_key_q [VOICE_COUNT];
  logic [VW-1:0]          next_q;
  logic [VOICE_COUNT-1:0] hit;
  logic [VW-1:0]          hit_v;
  logic                   out_vld_q;
  evt_t                   out_q;
  evt_t                   evt_d;

  assign pop_o       = q_valid_i & (~out_vld_q | evt_ready_i);
  assign evt_valid_o = out_vld_q;
  assign evt_o       = out_q;

  always_comb begin
    hit_v = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      hit[v] = own_vld_q[v] && (own_key_q[v] == q_data_i.key);
      if (hit[v]) begin
        hit_v = VW'(v);
      end
    end
  end

  always_comb begin
    evt_d = '0;
    unique case (q_data_i.kind)
      KIND_PRESS: begin
        evt_d.event_res   = EvStart;
        evt_d.voice_index = VoiceW'(next_q);
        evt_d.event_key   = q_data_i.key;
      end
      KIND_RELEASE: begin
        if (|hit) begin
          evt_d.event_res   = EvStop;
          evt_d.voice_index = VoiceW'(hit_v);
          evt_d.event_key   = q_data_i.key;
        end
      end
      default: evt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_vld_q <= '0;
      next_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        out_vld_q <= 1'b1;
      end else if (evt_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (pop_o) begin
        unique case (q_data_i.kind)
          KIND_PRESS: begin
            own_vld_q <= (own_vld_q & ~hit) | (VOICE_COUNT'(1) << next_q);
            next_q <= (next_q == VW'(VOICE_COUNT - 1)) ? '0 : next_q + VW'(1);
          end
          KIND_RELEASE: own_vld_q <= own_vld_q & ~hit;
          default:      own_vld_q <= own_vld_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= evt_d;
      if (q_data_i.kind == KIND_PRESS) begin
        own_key_q[next_q] <= q_data_i.key;
      end
    end
  end

endmodule
